@@ rtl/crre_pkg.sv @@
// ----------------------------------------------------------------------------
// crre_pkg
// shared types, codes and helpers of the chunked read request engine
// ----------------------------------------------------------------------------
package crre_pkg;

    localparam int unsigned DEF_MAX_OUTSTANDING = 16;
    localparam int unsigned RESULT_CAP          = 16;

    localparam int unsigned ADDR_W = 64;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned LIM_W  = 5;
    localparam int unsigned OFF_W  = 33;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned OP_W   = 2;
    localparam int unsigned KIND_W = 2;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [IDX_W-1:0]  t_reg_idx;
    typedef logic [1:0]        t_mul_sel;

    localparam t_op OP_START     = 2'd0;
    localparam t_op OP_COMPLETE  = 2'd1;
    localparam t_op OP_QUEUE_ERR = 2'd2;

    localparam t_kind KIND_REQUEST  = 2'd0;
    localparam t_kind KIND_DONE     = 2'd1;
    localparam t_kind KIND_FINISHED = 2'd2;
    localparam t_kind KIND_FAILED   = 2'd3;

    localparam t_reg_idx REG_REMOTE_BASE  = 3'd0;
    localparam t_reg_idx REG_REMOTE_KEY   = 3'd1;
    localparam t_reg_idx REG_LOCAL_BASE   = 3'd2;
    localparam t_reg_idx REG_LOCAL_KEY    = 3'd3;
    localparam t_reg_idx REG_TOTAL_LENGTH = 3'd4;
    localparam t_reg_idx REG_CHUNK_LENGTH = 3'd5;
    localparam t_reg_idx REG_OUT_LIMIT    = 3'd6;

    localparam t_mul_sel MUL_ID = 2'd0;
    localparam t_mul_sel MUL_CC = 2'd1;
    localparam t_mul_sel MUL_NC = 2'd2;

    typedef struct packed {
        logic     capture;
        logic     clear;
        logic     retire;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     save_off;
        logic     save_fin;
        logic     issue;
        logic     load;
        t_kind    kind;
        logic     last;
    } t_crre_cmd;

    typedef struct packed {
        logic out_free;
        logic cfg_bad;
        logic len_zero;
        logic id_bad;
        logic issue_last;
        logic fin;
        logic more;
    } t_crre_sts;

    function automatic logic [WORD_W-1:0] trim_len(input logic [ADDR_W-1:0] off,
                                                   input logic [WORD_W-1:0] total,
                                                   input logic [WORD_W-1:0] chunk);
        logic [ADDR_W-1:0] rem;
        rem = {{(ADDR_W-WORD_W){1'b0}}, total} - off;
        if (off >= {{(ADDR_W-WORD_W){1'b0}}, total}) begin
            return '0;
        end else if (rem < {{(ADDR_W-WORD_W){1'b0}}, chunk}) begin
            return rem[WORD_W-1:0];
        end else begin
            return chunk;
        end
    endfunction

endpackage

@@ rtl/crre_ctrl.sv @@
// ----------------------------------------------------------------------------
// crre_ctrl
// sequencer of the chunked read request engine: decodes words, steps the datapath
// ----------------------------------------------------------------------------
module crre_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  crre_pkg::t_op       i_operation,
    input  logic                i_success,
    input  crre_pkg::t_crre_sts i_sts,
    output crre_pkg::t_crre_cmd o_cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ISSUE     = 4'd1;
    localparam logic [3:0] S_FAIL      = 4'd2;
    localparam logic [3:0] S_FIN       = 4'd3;
    localparam logic [3:0] S_MUL_OFF   = 4'd4;
    localparam logic [3:0] S_MUL_FIN   = 4'd5;
    localparam logic [3:0] S_MUL_MORE  = 4'd6;
    localparam logic [3:0] S_DONE      = 4'd7;
    localparam logic [3:0] S_ISSUE_ONE = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_running, n_running;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_running <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_running <= n_running;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_running = r_running;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_operation == crre_pkg::OP_START) begin
                        if (!r_running) begin
                            if (i_sts.cfg_bad) begin
                                n_state = S_FAIL;
                            end else begin
                                o_cmd.clear = 1'b1;
                                if (i_sts.len_zero) begin
                                    n_state = S_FIN;
                                end else begin
                                    n_running = 1'b1;
                                    n_state   = S_ISSUE;
                                end
                            end
                        end
                    end else if (i_operation == crre_pkg::OP_COMPLETE ||
                                 i_operation == crre_pkg::OP_QUEUE_ERR) begin
                        if (r_running) begin
                            if (i_operation == crre_pkg::OP_QUEUE_ERR || !i_success) begin
                                n_running = 1'b0;
                                n_state   = S_FAIL;
                            end else if (!i_sts.id_bad) begin
                                n_state = S_MUL_OFF;
                            end
                        end
                    end
                end
            end
            S_ISSUE: begin
                if (i_sts.out_free) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.kind  = crre_pkg::KIND_REQUEST;
                    o_cmd.issue = 1'b1;
                    o_cmd.last  = i_sts.issue_last;
                    if (i_sts.issue_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FAIL: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.kind = crre_pkg::KIND_FAILED;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.kind = crre_pkg::KIND_FINISHED;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_MUL_OFF: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = crre_pkg::MUL_ID;
                o_cmd.retire  = 1'b1;
                n_state       = S_MUL_FIN;
            end
            S_MUL_FIN: begin
                o_cmd.save_off = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = crre_pkg::MUL_CC;
                n_state        = S_MUL_MORE;
            end
            S_MUL_MORE: begin
                o_cmd.save_fin = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = crre_pkg::MUL_NC;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.kind = crre_pkg::KIND_DONE;
                    o_cmd.last = !(i_sts.fin || i_sts.more);
                    if (i_sts.fin) begin
                        n_running = 1'b0;
                        n_state   = S_FIN;
                    end else if (i_sts.more) begin
                        n_state = S_ISSUE_ONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ISSUE_ONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.kind  = crre_pkg::KIND_REQUEST;
                    o_cmd.issue = 1'b1;
                    o_cmd.last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/crre_dp.sv @@
// ----------------------------------------------------------------------------
// crre_dp
// datapath: settings, chunk counters, shared multiplier and output register
// ----------------------------------------------------------------------------
module crre_dp #(
    parameter int unsigned MAX_OUTSTANDING = crre_pkg::DEF_MAX_OUTSTANDING
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  crre_pkg::t_reg_idx                i_cfg_index,
    input  logic [crre_pkg::ADDR_W-1:0]       i_cfg_data,
    input  logic [crre_pkg::WORD_W-1:0]       i_chunk_id,
    input  logic                              i_out_ready,
    input  crre_pkg::t_crre_cmd               i_cmd,
    output crre_pkg::t_crre_sts               o_sts,
    output logic                              o_out_valid,
    output crre_pkg::t_kind                   o_kind,
    output logic [crre_pkg::WORD_W-1:0]       o_request_id,
    output logic [crre_pkg::ADDR_W-1:0]       o_remote_addr,
    output logic [crre_pkg::ADDR_W-1:0]       o_local_addr,
    output logic [crre_pkg::WORD_W-1:0]       o_length,
    output logic [crre_pkg::WORD_W-1:0]       o_remote_key_out,
    output logic [crre_pkg::WORD_W-1:0]       o_local_key_out,
    output logic                              o_last
);

    localparam int unsigned AW = crre_pkg::ADDR_W;
    localparam int unsigned WW = crre_pkg::WORD_W;
    localparam int unsigned LW = crre_pkg::LIM_W;
    localparam int unsigned OW = crre_pkg::OFF_W;
    localparam int unsigned CAP_INT = (MAX_OUTSTANDING < crre_pkg::RESULT_CAP) ?
                                      MAX_OUTSTANDING : crre_pkg::RESULT_CAP;
    localparam logic [LW-1:0] LIM_CAP = LW'(CAP_INT);

    logic [AW-1:0] r_remote_base, r_local_base;
    logic [WW-1:0] r_remote_key, r_local_key, r_total_len, r_chunk_len;
    logic [LW-1:0] r_limit;

    logic [WW-1:0] r_nc, r_cc, r_id;
    logic [OW-1:0] r_noff;
    logic [LW-1:0] r_inflight;
    logic [AW-1:0] r_prod, r_off;
    logic          r_fin;

    logic [WW-1:0] mul_a;
    logic [AW-1:0] total_ext;
    logic [LW-1:0] lim;
    logic [OW:0]   noff_step;
    logic [LW:0]   inflight_step;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remote_base <= '0;
            r_remote_key  <= '0;
            r_local_base  <= '0;
            r_local_key   <= '0;
            r_total_len   <= '0;
            r_chunk_len   <= '0;
            r_limit       <= LW'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                crre_pkg::REG_REMOTE_BASE:  r_remote_base <= i_cfg_data;
                crre_pkg::REG_REMOTE_KEY:   r_remote_key  <= i_cfg_data[WW-1:0];
                crre_pkg::REG_LOCAL_BASE:   r_local_base  <= i_cfg_data;
                crre_pkg::REG_LOCAL_KEY:    r_local_key   <= i_cfg_data[WW-1:0];
                crre_pkg::REG_TOTAL_LENGTH: r_total_len   <= i_cfg_data[WW-1:0];
                crre_pkg::REG_CHUNK_LENGTH: r_chunk_len   <= i_cfg_data[WW-1:0];
                crre_pkg::REG_OUT_LIMIT:    r_limit       <= i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    assign total_ext     = {{(AW-WW){1'b0}}, r_total_len};
    assign lim           = (r_limit > LIM_CAP) ? LIM_CAP : r_limit;
    assign noff_step     = {1'b0, r_noff} + {{(OW+1-WW){1'b0}}, r_chunk_len};
    assign inflight_step = {1'b0, r_inflight} + (LW+1)'(1);

    always_comb begin
        unique case (i_cmd.mul_sel)
            crre_pkg::MUL_ID: mul_a = r_id;
            crre_pkg::MUL_CC: mul_a = r_cc;
            crre_pkg::MUL_NC: mul_a = r_nc;
            default:          mul_a = r_nc;
        endcase
    end

    // chunk counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc       <= '0;
            r_noff     <= '0;
            r_inflight <= '0;
            r_cc       <= '0;
        end else if (i_cmd.clear) begin
            r_nc       <= '0;
            r_noff     <= '0;
            r_inflight <= '0;
            r_cc       <= '0;
        end else if (i_cmd.issue) begin
            r_nc       <= r_nc + WW'(1);
            r_noff     <= noff_step[OW-1:0];
            r_inflight <= inflight_step[LW-1:0];
        end else if (i_cmd.retire) begin
            r_cc       <= r_cc + WW'(1);
            r_inflight <= r_inflight - LW'(1);
        end
    end

    // multiplier and completion scratch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_id <= i_chunk_id;
        end
        if (i_cmd.mul_en) begin
            r_prod <= AW'(mul_a) * AW'(r_chunk_len);
        end
        if (i_cmd.save_off) begin
            r_off <= r_prod;
        end
        if (i_cmd.save_fin) begin
            // zero chunk size means zero chunks, so any completion finishes
            r_fin <= (r_chunk_len == '0) || (r_prod >= total_ext);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_kind <= i_cmd.kind;
            o_last <= i_cmd.last;
            unique case (i_cmd.kind)
                crre_pkg::KIND_REQUEST: begin
                    o_request_id     <= r_nc;
                    o_remote_addr    <= r_remote_base + AW'(r_noff);
                    o_local_addr     <= r_local_base + AW'(r_noff);
                    o_length         <= crre_pkg::trim_len(AW'(r_noff), r_total_len,
                                                           r_chunk_len);
                    o_remote_key_out <= r_remote_key;
                    o_local_key_out  <= r_local_key;
                end
                crre_pkg::KIND_DONE: begin
                    o_request_id     <= r_id;
                    o_remote_addr    <= '0;
                    o_local_addr     <= r_local_base + r_off;
                    o_length         <= crre_pkg::trim_len(r_off, r_total_len, r_chunk_len);
                    o_remote_key_out <= '0;
                    o_local_key_out  <= '0;
                end
                crre_pkg::KIND_FINISHED, crre_pkg::KIND_FAILED: begin
                    o_request_id     <= '0;
                    o_remote_addr    <= '0;
                    o_local_addr     <= '0;
                    o_length         <= '0;
                    o_remote_key_out <= '0;
                    o_local_key_out  <= '0;
                end
            endcase
        end
    end

    // status to controller
    always_comb begin
        o_sts.out_free   = !o_out_valid || i_out_ready;
        o_sts.cfg_bad    = (r_chunk_len == '0) || (r_limit == '0);
        o_sts.len_zero   = (r_total_len == '0);
        o_sts.id_bad     = (i_chunk_id >= r_nc) || (r_inflight == '0);
        o_sts.issue_last = (inflight_step >= {1'b0, lim}) ||
                           (noff_step >= (OW+1)'(r_total_len));
        o_sts.fin        = r_fin;
        o_sts.more       = (r_prod < total_ext) && (r_inflight < lim);
    end

endmodule

@@ rtl/chunked_read_request_engine.sv @@
// ----------------------------------------------------------------------------
// chunked_read_request_engine
// splits a transfer into chunk read requests with a cap on requests in flight
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  in        in   i_in_valid / o_in_ready   i_operation, i_chunk_id, i_success
//  out       out  o_out_valid / i_out_ready o_kind .. o_last
//  cfg       in   i_cfg_we                  i_cfg_index, i_cfg_data
//
//  one word is taken at a time; a start yields its requests one per cycle after
//  the accept cycle, a successful completion holds the input while it passes
//  through the shared 32x32 multiplier (offset, finish test, next-request test)
//  a single output register holds each result; a stalled output holds the sequencer
//  synchronous active-low reset; settings reset to zero, the in-flight limit to one
// ----------------------------------------------------------------------------
module chunked_read_request_engine #(
    parameter int unsigned MAX_OUTSTANDING = crre_pkg::DEF_MAX_OUTSTANDING
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  crre_pkg::t_reg_idx                i_cfg_index,
    input  logic [crre_pkg::ADDR_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  crre_pkg::t_op                     i_operation,
    input  logic [crre_pkg::WORD_W-1:0]       i_chunk_id,
    input  logic                              i_success,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output crre_pkg::t_kind                   o_kind,
    output logic [crre_pkg::WORD_W-1:0]       o_request_id,
    output logic [crre_pkg::ADDR_W-1:0]       o_remote_addr,
    output logic [crre_pkg::ADDR_W-1:0]       o_local_addr,
    output logic [crre_pkg::WORD_W-1:0]       o_length,
    output logic [crre_pkg::WORD_W-1:0]       o_remote_key_out,
    output logic [crre_pkg::WORD_W-1:0]       o_local_key_out,
    output logic                              o_last
);

    crre_pkg::t_crre_cmd cmd;
    crre_pkg::t_crre_sts sts;

    crre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_success   (i_success),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    crre_dp #(
        .MAX_OUTSTANDING (MAX_OUTSTANDING)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_chunk_id       (i_chunk_id),
        .i_out_ready      (i_out_ready),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_out_valid      (o_out_valid),
        .o_kind           (o_kind),
        .o_request_id     (o_request_id),
        .o_remote_addr    (o_remote_addr),
        .o_local_addr     (o_local_addr),
        .o_length         (o_length),
        .o_remote_key_out (o_remote_key_out),
        .o_local_key_out  (o_local_key_out),
        .o_last           (o_last)
    );

endmodule

@@ verif/chunked_read_request_engine_test.sv @@
// ----------------------------------------------------------------------------
// chunked_read_request_engine_test
// self-checking bench for the chunked read request engine. a queue-fed driver
// offers words with random gaps, and a monitor stalls the result side at random.
// each accepted word goes through a cycle-free model of the engine, and every
// result is compared field by field with the oldest one predicted.
// a short directed part covers the corner cases, then randomized transfers
// follow: settings change between phases while the engine is quiet, and one
// long result-side hold-off backs up the input.
// ----------------------------------------------------------------------------
module chunked_read_request_engine_test;

    localparam crre_pkg::t_op OP_UNUSED = 2'd3;
    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  SETTLE_CYCLES = 16;
    localparam int  HOLD_CYCLES   = 400;
    localparam int  HOLD_BACKLOG  = 8;
    localparam int  WORD_TARGET   = 525;
    localparam int  MAX_REPORTS   = 10;

    typedef struct {
        crre_pkg::t_op               op;
        logic [crre_pkg::WORD_W-1:0] id;
        logic                        ok;
    } t_engine_word;

    typedef struct {
        crre_pkg::t_kind             kind;
        logic [crre_pkg::WORD_W-1:0] id;
        logic [crre_pkg::ADDR_W-1:0] raddr;
        logic [crre_pkg::ADDR_W-1:0] laddr;
        logic [crre_pkg::WORD_W-1:0] len;
        logic [crre_pkg::WORD_W-1:0] rkey;
        logic [crre_pkg::WORD_W-1:0] lkey;
        logic                        last;
    } t_read_result;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_we    = 1'b0;
    crre_pkg::t_reg_idx          i_cfg_index = crre_pkg::REG_REMOTE_BASE;
    logic [crre_pkg::ADDR_W-1:0] i_cfg_data  = '0;
    logic                        i_in_valid  = 1'b0;
    logic                        o_in_ready;
    crre_pkg::t_op               i_operation = crre_pkg::OP_START;
    logic [crre_pkg::WORD_W-1:0] i_chunk_id  = '0;
    logic                        i_success   = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    crre_pkg::t_kind             o_kind;
    logic [crre_pkg::WORD_W-1:0] o_request_id;
    logic [crre_pkg::ADDR_W-1:0] o_remote_addr;
    logic [crre_pkg::ADDR_W-1:0] o_local_addr;
    logic [crre_pkg::WORD_W-1:0] o_length;
    logic [crre_pkg::WORD_W-1:0] o_remote_key_out;
    logic [crre_pkg::WORD_W-1:0] o_local_key_out;
    logic                        o_last;

    // register copies
    logic [crre_pkg::ADDR_W-1:0] cfg_remote_base = '0;
    logic [crre_pkg::WORD_W-1:0] cfg_remote_key  = '0;
    logic [crre_pkg::ADDR_W-1:0] cfg_local_base  = '0;
    logic [crre_pkg::WORD_W-1:0] cfg_local_key   = '0;
    logic [crre_pkg::WORD_W-1:0] cfg_total       = '0;
    logic [crre_pkg::WORD_W-1:0] cfg_chunk       = '0;
    logic [crre_pkg::LIM_W-1:0]  cfg_limit       = 5'd1;

    // engine state
    logic                        eng_running    = 1'b0;
    logic [crre_pkg::WORD_W-1:0] eng_next_chunk = '0;
    logic [crre_pkg::OFF_W-1:0]  eng_next_off   = '0;
    logic [crre_pkg::LIM_W-1:0]  eng_in_flight  = '0;
    logic [crre_pkg::WORD_W-1:0] eng_done       = '0;

    t_engine_word word_q[$];
    t_read_result awaited_out[$];
    t_engine_word next_word;
    t_read_result want;

    int words_pushed = 0;
    int words_taken  = 0;
    int results_seen = 0;
    int faults       = 0;
    int cyc          = 0;
    int hold_left    = 0;
    bit held_once    = 1'b0;
    logic calm;

    assign calm = (cyc % 2000) >= 1400;

    chunked_read_request_engine u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_chunk_id       (i_chunk_id),
        .i_success        (i_success),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_request_id     (o_request_id),
        .o_remote_addr    (o_remote_addr),
        .o_local_addr     (o_local_addr),
        .o_length         (o_length),
        .o_remote_key_out (o_remote_key_out),
        .o_local_key_out  (o_local_key_out),
        .o_last           (o_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] chunk_total();
        if (cfg_chunk == '0) begin
            return '0;
        end
        return ({32'b0, cfg_total} + {32'b0, cfg_chunk} - 64'd1) / {32'b0, cfg_chunk};
    endfunction

    function automatic logic [crre_pkg::LIM_W-1:0] lane_limit();
        int unsigned cap;
        cap = cfg_limit;
        if (cap > crre_pkg::DEF_MAX_OUTSTANDING) begin
            cap = crre_pkg::DEF_MAX_OUTSTANDING;
        end
        if (cap > crre_pkg::RESULT_CAP) begin
            cap = crre_pkg::RESULT_CAP;
        end
        return cap[crre_pkg::LIM_W-1:0];
    endfunction

    function automatic logic [crre_pkg::WORD_W-1:0] trimmed_bytes(
        input logic [crre_pkg::ADDR_W-1:0] off);
        logic [crre_pkg::ADDR_W-1:0] left;
        if (off >= {32'b0, cfg_total}) begin
            return '0;
        end
        left = {32'b0, cfg_total} - off;
        if (left < {32'b0, cfg_chunk}) begin
            return left[crre_pkg::WORD_W-1:0];
        end
        return cfg_chunk;
    endfunction

    function automatic void note_result(input crre_pkg::t_kind kind,
                                        input logic [crre_pkg::WORD_W-1:0] id,
                                        input logic [crre_pkg::ADDR_W-1:0] raddr,
                                        input logic [crre_pkg::ADDR_W-1:0] laddr,
                                        input logic [crre_pkg::WORD_W-1:0] len,
                                        input logic [crre_pkg::WORD_W-1:0] rkey,
                                        input logic [crre_pkg::WORD_W-1:0] lkey);
        t_read_result r;
        r.kind  = kind;
        r.id    = id;
        r.raddr = raddr;
        r.laddr = laddr;
        r.len   = len;
        r.rkey  = rkey;
        r.lkey  = lkey;
        r.last  = 1'b0;
        awaited_out.push_back(r);
    endfunction

    function automatic void note_status(input crre_pkg::t_kind kind);
        note_result(kind, '0, '0, '0, '0, '0, '0);
    endfunction

    function automatic void issue_request();
        logic [crre_pkg::ADDR_W-1:0] off;
        off = {31'b0, eng_next_off};
        note_result(crre_pkg::KIND_REQUEST, eng_next_chunk, cfg_remote_base + off,
                    cfg_local_base + off, trimmed_bytes(off), cfg_remote_key,
                    cfg_local_key);
        eng_next_chunk = eng_next_chunk + 1'b1;
        eng_next_off   = eng_next_off + {1'b0, cfg_chunk};
        eng_in_flight  = eng_in_flight + 1'b1;
    endfunction

    function automatic void advance_engine(input crre_pkg::t_op op,
                                           input logic [crre_pkg::WORD_W-1:0] id,
                                           input logic ok);
        int unsigned                 before_n;
        logic [crre_pkg::ADDR_W-1:0] off;
        before_n = awaited_out.size();
        case (op)
            crre_pkg::OP_START: begin
                if (!eng_running) begin
                    if (cfg_chunk == '0 || cfg_limit == '0) begin
                        note_status(crre_pkg::KIND_FAILED);
                    end else begin
                        eng_next_chunk = '0;
                        eng_next_off   = '0;
                        eng_in_flight  = '0;
                        eng_done       = '0;
                        if (chunk_total() == '0) begin
                            note_status(crre_pkg::KIND_FINISHED);
                        end else begin
                            eng_running = 1'b1;
                            while (eng_in_flight < lane_limit() &&
                                   {32'b0, eng_next_chunk} < chunk_total()) begin
                                issue_request();
                            end
                        end
                    end
                end
            end
            crre_pkg::OP_COMPLETE, crre_pkg::OP_QUEUE_ERR: begin
                if (eng_running) begin
                    if (op == crre_pkg::OP_QUEUE_ERR || !ok) begin
                        eng_running = 1'b0;
                        note_status(crre_pkg::KIND_FAILED);
                    end else if (id < eng_next_chunk && eng_in_flight != '0) begin
                        off = {32'b0, id} * {32'b0, cfg_chunk};
                        note_result(crre_pkg::KIND_DONE, id, '0, cfg_local_base + off,
                                    trimmed_bytes(off), '0, '0);
                        eng_done      = eng_done + 1'b1;
                        eng_in_flight = eng_in_flight - 1'b1;
                        if ({32'b0, eng_done} >= chunk_total()) begin
                            eng_running = 1'b0;
                            note_status(crre_pkg::KIND_FINISHED);
                        end else if (eng_in_flight < lane_limit() &&
                                     {32'b0, eng_next_chunk} < chunk_total()) begin
                            issue_request();
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        if (awaited_out.size() > before_n) begin
            awaited_out[awaited_out.size()-1].last = 1'b1;
        end
    endfunction

    function automatic void log_fault(input string what);
        if (faults < MAX_REPORTS) begin
            $display("%s", what);
        end
        faults++;
    endfunction

    // input side driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                advance_engine(i_operation, i_chunk_id, i_success);
                words_taken <= words_taken + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (word_q.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
                    next_word = word_q.pop_front();
                    i_in_valid  <= 1'b1;
                    i_operation <= next_word.op;
                    i_chunk_id  <= next_word.id;
                    i_success   <= next_word.ok;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result side ready, with one long hold-off once the input backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!held_once && words_pushed - words_taken >= HOLD_BACKLOG) begin
            held_once   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= 32);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen <= results_seen + 1;
            if (awaited_out.size() == 0) begin
                log_fault($sformatf("result %0d unexpected: kind %0d id %h", results_seen,
                                    o_kind, o_request_id));
            end else begin
                want = awaited_out.pop_front();
                if (o_kind !== want.kind || o_request_id !== want.id ||
                    o_remote_addr !== want.raddr || o_local_addr !== want.laddr ||
                    o_length !== want.len || o_remote_key_out !== want.rkey ||
                    o_local_key_out !== want.lkey || o_last !== want.last) begin
                    log_fault($sformatf({"result %0d mismatch (exp/got): kind %0d/%0d ",
                                         "id %h/%h raddr %h/%h laddr %h/%h len %h/%h ",
                                         "rkey %h/%h lkey %h/%h last %b/%b"},
                                        results_seen, want.kind, o_kind, want.id,
                                        o_request_id, want.raddr, o_remote_addr,
                                        want.laddr, o_local_addr, want.len, o_length,
                                        want.rkey, o_remote_key_out, want.lkey,
                                        o_local_key_out, want.last, o_last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_word(input crre_pkg::t_op op,
                             input logic [crre_pkg::WORD_W-1:0] id, input logic ok);
        t_engine_word w;
        w.op = op;
        w.id = id;
        w.ok = ok;
        word_q.push_back(w);
        words_pushed++;
    endtask

    // wait until every word is taken and every result is back, then let the engine go quiet
    task automatic settle();
        @(posedge i_clk);
        while (words_taken != words_pushed || awaited_out.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input crre_pkg::t_reg_idx idx,
                             input logic [crre_pkg::ADDR_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            crre_pkg::REG_REMOTE_BASE:  cfg_remote_base = data;
            crre_pkg::REG_REMOTE_KEY:   cfg_remote_key  = data[crre_pkg::WORD_W-1:0];
            crre_pkg::REG_LOCAL_BASE:   cfg_local_base  = data;
            crre_pkg::REG_LOCAL_KEY:    cfg_local_key   = data[crre_pkg::WORD_W-1:0];
            crre_pkg::REG_TOTAL_LENGTH: cfg_total       = data[crre_pkg::WORD_W-1:0];
            crre_pkg::REG_CHUNK_LENGTH: cfg_chunk       = data[crre_pkg::WORD_W-1:0];
            crre_pkg::REG_OUT_LIMIT:    cfg_limit       = data[crre_pkg::LIM_W-1:0];
            default: begin
            end
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [crre_pkg::ADDR_W-1:0] rbase,
                            input logic [crre_pkg::WORD_W-1:0] rkey,
                            input logic [crre_pkg::ADDR_W-1:0] lbase,
                            input logic [crre_pkg::WORD_W-1:0] lkey,
                            input logic [crre_pkg::WORD_W-1:0] total,
                            input logic [crre_pkg::WORD_W-1:0] chunk,
                            input logic [crre_pkg::LIM_W-1:0] lim);
        logic [crre_pkg::ADDR_W-1:0] junk;
        junk = {$urandom, $urandom};
        write_reg(crre_pkg::REG_REMOTE_BASE, rbase);
        write_reg(crre_pkg::REG_REMOTE_KEY, {junk[63:32], rkey});
        write_reg(crre_pkg::REG_LOCAL_BASE, lbase);
        write_reg(crre_pkg::REG_LOCAL_KEY, {junk[63:32], lkey});
        write_reg(crre_pkg::REG_TOTAL_LENGTH, {junk[63:32], total});
        write_reg(crre_pkg::REG_CHUNK_LENGTH, {junk[63:32], chunk});
        write_reg(crre_pkg::REG_OUT_LIMIT, {junk[63:crre_pkg::LIM_W], lim});
    endtask

    task automatic random_settings();
        logic [63:0]                 span;
        logic [crre_pkg::WORD_W-1:0] chunk;
        logic [crre_pkg::WORD_W-1:0] total;
        logic [crre_pkg::LIM_W-1:0]  lim;
        int unsigned                 mode;
        mode  = $urandom_range(9);
        chunk = ($urandom >> $urandom_range(5, 31)) + 1;
        span  = {32'b0, chunk} * $urandom_range(1, 20) - $urandom_range(0, chunk - 1);
        total = span[crre_pkg::WORD_W-1:0];
        if ($urandom_range(7) == 0) begin
            lim = crre_pkg::LIM_W'($urandom_range(17, 31));
        end else begin
            lim = crre_pkg::LIM_W'($urandom_range(1, 16));
        end
        case (mode)
            0: begin
                if ($urandom_range(1) == 1) begin
                    chunk = '0;
                end else begin
                    lim = '0;
                end
            end
            1: total = '0;
            2: begin
                chunk = $urandom | 32'h8000_0000;
                total = $urandom;
            end
            3: begin
                chunk = $urandom_range(1, 8);
                total = $urandom_range(0, 40);
            end
            default: begin
            end
        endcase
        set_regs({$urandom, $urandom}, $urandom, {$urandom, $urandom}, $urandom,
                 total, chunk, lim);
    endtask

    // one start, completions for issued chunks with some noise, and a stop if cut short
    task automatic run_transfer();
        logic [63:0]                 total_n;
        logic [63:0]                 issued;
        logic [63:0]                 budget;
        logic [63:0]                 done_n;
        logic [crre_pkg::WORD_W-1:0] id;
        int unsigned                 lim;
        int unsigned                 pick;
        push_word(crre_pkg::OP_START, $urandom, 1'($urandom_range(1)));
        total_n = chunk_total();
        lim     = lane_limit();
        if (cfg_chunk != '0 && cfg_limit != '0 && total_n != '0) begin
            budget = total_n;
            if (total_n > 40) begin
                budget = 64'($urandom_range(30));
            end else if ($urandom_range(9) == 0) begin
                budget = 64'($urandom_range(total_n[31:0] - 1));
            end
            done_n = '0;
            while (done_n < budget) begin
                issued = (done_n + lim < total_n) ? done_n + lim : total_n;
                pick   = $urandom_range(99);
                if (pick < 4) begin
                    push_word(OP_UNUSED, $urandom, 1'($urandom_range(1)));
                end else if (pick < 7) begin
                    push_word(crre_pkg::OP_START, $urandom, 1'($urandom_range(1)));
                end else if (pick < 11) begin
                    id = $urandom;
                    if (id < issued) begin
                        id = issued[crre_pkg::WORD_W-1:0];
                    end
                    push_word(crre_pkg::OP_COMPLETE, id, 1'b1);
                end else begin
                    push_word(crre_pkg::OP_COMPLETE, $urandom_range(issued[31:0] - 1), 1'b1);
                    done_n++;
                end
            end
            if (done_n < total_n) begin
                if ($urandom_range(1) == 1) begin
                    push_word(crre_pkg::OP_QUEUE_ERR, $urandom, 1'($urandom_range(1)));
                end else begin
                    push_word(crre_pkg::OP_COMPLETE, $urandom, 1'b0);
                end
            end
        end
        if ($urandom_range(4) == 0) begin
            pick = $urandom_range(2);
            push_word(pick == 0 ? crre_pkg::OP_COMPLETE :
                      (pick == 1 ? crre_pkg::OP_QUEUE_ERR : OP_UNUSED),
                      $urandom, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero chunk size, then words while idle
        push_word(crre_pkg::OP_START, '0, 1'b1);
        push_word(crre_pkg::OP_COMPLETE, '0, 1'b1);
        push_word(crre_pkg::OP_QUEUE_ERR, '0, 1'b1);
        push_word(OP_UNUSED, 32'hFFFF_FFFF, 1'b1);
        settle();

        // zero limit
        set_regs(64'hFFFF_FFFF_FFFF_FF00, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0,
                 32'hA5A5_5A5A, 32'd100, 32'd30, 5'd0);
        push_word(crre_pkg::OP_START, '0, 1'b0);
        settle();

        // oversized limit, address wrap, trimmed last chunk, ignored words
        write_reg(crre_pkg::REG_OUT_LIMIT, 64'd31);
        push_word(crre_pkg::OP_START, '0, 1'b1);
        push_word(crre_pkg::OP_START, 32'h1234_5678, 1'b0);
        push_word(crre_pkg::OP_COMPLETE, 32'd7, 1'b1);
        push_word(crre_pkg::OP_COMPLETE, 32'hFFFF_FFFF, 1'b1);
        push_word(crre_pkg::OP_COMPLETE, 32'd3, 1'b1);
        push_word(crre_pkg::OP_COMPLETE, 32'd0, 1'b1);
        push_word(crre_pkg::OP_COMPLETE, 32'd1, 1'b1);
        push_word(crre_pkg::OP_COMPLETE, 32'd2, 1'b1);
        settle();

        // empty transfer
        set_regs('0, '0, '0, '0, '0, 32'd5, 5'd2);
        push_word(crre_pkg::OP_START, 32'hFFFF_FFFF, 1'b0);
        settle();

        // largest lengths, single chunk
        set_regs({$urandom, $urandom}, $urandom, {$urandom, $urandom}, $urandom,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1);
        push_word(crre_pkg::OP_START, '0, 1'b1);
        push_word(crre_pkg::OP_COMPLETE, '0, 1'b1);
        settle();

        // huge chunk count, full window, failed completion
        set_regs({$urandom, $urandom}, $urandom, {$urandom, $urandom}, $urandom,
                 32'hFFFF_FFFF, 32'd1, 5'd16);
        push_word(crre_pkg::OP_START, '0, 1'b1);
        for (int k = 0; k < 8; k++) begin
            push_word(crre_pkg::OP_COMPLETE, k, 1'b1);
        end
        push_word(crre_pkg::OP_COMPLETE, 32'd8, 1'b0);
        settle();

        while (words_pushed < WORD_TARGET) begin
            random_settings();
            repeat ($urandom_range(1, 3)) run_transfer();
            settle();
        end

        if (faults == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
